### rtl/mbw_pkg.sv
package mbw_pkg;

  // ASCII codes inserted around the base64 symbols.
  localparam logic [6:0] CH_CR  = 7'd13;
  localparam logic [6:0] CH_LF  = 7'd10;
  localparam logic [6:0] CH_PAD = 7'd61;

  localparam logic [7:0] GROUPS_PER_LINE_RST = 8'd19;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration register map (word index taken from paddr[2]).
  localparam logic REG_GROUPS_PER_LINE = 1'b0;
  localparam int unsigned PADDR_W = 3;

  // One classified input byte: the base64 symbols and pads it produces,
  // whether a CR LF follows them, and whether it closes the stream.
  typedef struct packed {
    logic [3:0][6:0] chars;
    logic [2:0]      nsym;
    logic            crlf;
    logic            fin;
  } job_t;

  function automatic logic [6:0] b64_sym(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'd71 + {1'b0, v};
    end else if (v < 6'd62) begin
      r = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      r = 7'd43;
    end else begin
      r = 7'd47;
    end
    return r;
  endfunction

endpackage

### rtl/mime_base64_line_wrapper_top.sv
// Base64 encoder with MIME line wrapping. Each input request carries one raw
// byte (tlast marks the last byte of the stream); each output request carries
// one ASCII character: a base64 symbol, '=', CR or LF. tlast on the output
// marks the last character caused by an input byte and tuser marks the last
// character of the stream, which is always the LF of a closing CR LF. A CR LF
// is inserted after every groups_per_line four-character groups (register at
// byte address 0, reset 19, zero meaning 256). The output side delivers one
// character per cycle while the receiver is ready, and an input byte yields
// one to six characters, about 1.37 on average for long streams. The input
// side takes a byte every cycle while the four-entry queue between the
// classifier and the character sequencer has room.
module mime_base64_line_wrapper_top
  import mbw_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // [6:0] text_char, [7] zero
  output logic               m_axis_tlast,
  output logic               m_axis_tuser,   // [0] stream_end
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0] groups_per_line_q;
  logic       cfg_write;

  job_t       front_job;
  logic       front_valid;
  logic       queue_ready;
  job_t       head_job;
  logic       head_valid;
  logic       head_pop;
  logic [6:0] text_char;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_GROUPS_PER_LINE);
  assign prdata    = (paddr[2] == REG_GROUPS_PER_LINE) ? {24'd0, groups_per_line_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      groups_per_line_q <= GROUPS_PER_LINE_RST;
    end else if (cfg_write) begin
      groups_per_line_q <= pwdata[7:0];
    end
  end

  mbw_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .data_byte_i       (s_axis_tdata),
    .is_final_i        (s_axis_tlast),
    .groups_per_line_i (groups_per_line_q),
    .job_o             (front_job),
    .job_valid_o       (front_valid),
    .job_ready_i       (queue_ready)
  );

  mbw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_job_i   (front_job),
    .wr_valid_i (front_valid),
    .wr_ready_o (queue_ready),
    .rd_job_o   (head_job),
    .rd_valid_o (head_valid),
    .rd_pop_i   (head_pop)
  );

  mbw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (head_job),
    .job_valid_i  (head_valid),
    .job_pop_o    (head_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .text_char_o  (text_char),
    .run_end_o    (m_axis_tlast),
    .stream_end_o (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, text_char};

`ifndef SYNTHESIS
  // The end of the stream is also the end of the last byte's characters.
  a_stream_end_is_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (text_char == CH_LF))
    else $error("stream end not on the closing LF");

  // Every queued byte yields between one and four symbols.
  a_symbol_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid |-> (head_job.nsym != 3'd0) && (head_job.nsym <= 3'd4))
    else $error("queued request has a bad symbol count");

  // A final byte always closes the line.
  a_final_has_crlf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid && head_job.fin |-> head_job.crlf)
    else $error("final request without closing CR LF");

  // The queue head leaves only on a cycle that loads an output character.
  a_pop_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |=> m_axis_tvalid && m_axis_tlast)
    else $error("queue popped without delivering the last character");
`endif

endmodule

### rtl/mbw_front.sv
module mbw_front
  import mbw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       is_final_i,
  input  logic [7:0] groups_per_line_i,
  output job_t       job_o,
  output logic       job_valid_o,
  input  logic       job_ready_i
);

  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic [7:0] gil_q, gil_d;

  logic       accept;
  logic       gdone;
  logic       close;
  logic [8:0] count9;
  logic [8:0] limit9;
  job_t       job;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign accept      = in_valid_i && job_ready_i;
  assign job_o       = job;

  // Zero programmed groups means 256 groups per line.
  assign count9 = {1'b0, gil_q} + 9'd1;
  assign limit9 = (groups_per_line_i == 8'd0) ? 9'd256 : {1'b0, groups_per_line_i};
  assign close  = (count9 >= limit9);

  always_comb begin
    job       = '0;
    job.fin   = is_final_i;
    gdone     = 1'b0;
    phase_d   = phase_q;
    carry_d   = carry_q;
    unique case (phase_q)
      PH_1: begin
        job.chars[0] = b64_sym({carry_q[1:0], data_byte_i[7:4]});
        job.nsym     = 3'd1;
        carry_d      = data_byte_i[3:0];
        phase_d      = PH_2;
        if (is_final_i) begin
          job.chars[1] = b64_sym({data_byte_i[3:0], 2'b00});
          job.chars[2] = CH_PAD;
          job.nsym     = 3'd3;
          gdone        = 1'b1;
        end
      end
      PH_2: begin
        job.chars[0] = b64_sym({carry_q, data_byte_i[7:6]});
        job.chars[1] = b64_sym(data_byte_i[5:0]);
        job.nsym     = 3'd2;
        carry_d      = 4'd0;
        phase_d      = PH_0;
        gdone        = 1'b1;
      end
      default: begin
        job.chars[0] = b64_sym(data_byte_i[7:2]);
        job.nsym     = 3'd1;
        carry_d      = {2'b00, data_byte_i[1:0]};
        phase_d      = PH_1;
        if (is_final_i) begin
          job.chars[1] = b64_sym({data_byte_i[1:0], 4'b0000});
          job.chars[2] = CH_PAD;
          job.chars[3] = CH_PAD;
          job.nsym     = 3'd4;
          gdone        = 1'b1;
        end
      end
    endcase

    // The end of a stream always closes the line, either by a full group
    // or by the trailing CR LF of a partial line.
    job.crlf = (gdone && close) || is_final_i;

    gil_d = gil_q;
    if (is_final_i) begin
      gil_d   = 8'd0;
      phase_d = PH_0;
      carry_d = 4'd0;
    end else if (gdone) begin
      gil_d = close ? 8'd0 : count9[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_0;
      carry_q <= 4'd0;
      gil_q   <= 8'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
      gil_q   <= gil_d;
    end
  end

endmodule

### rtl/mbw_queue.sv
module mbw_queue
  import mbw_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t wr_job_i,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  output job_t rd_job_o,
  output logic rd_valid_o,
  input  logic rd_pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            pop;

  assign wr_ready_o = (count_q != CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_job_o   = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### rtl/mbw_back.sv
module mbw_back
  import mbw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       job_valid_i,
  output logic       job_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] text_char_o,
  output logic       run_end_o,
  output logic       stream_end_o
);

  logic [2:0] idx_q;
  logic [2:0] total;
  logic       last;
  logic       advance;
  logic [6:0] ch;
  logic       out_valid_q;
  logic [6:0] char_q;
  logic       run_end_q;
  logic       stream_end_q;

  assign total   = job_i.nsym + (job_i.crlf ? 3'd2 : 3'd0);
  assign last    = (idx_q == total - 3'd1);
  assign advance = job_valid_i && (!out_valid_q || out_ready_i);

  assign job_pop_o = advance && last;

  always_comb begin
    if (idx_q < job_i.nsym) begin
      ch = job_i.chars[idx_q[1:0]];
    end else if (idx_q == job_i.nsym) begin
      ch = CH_CR;
    end else begin
      ch = CH_LF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        idx_q       <= last ? 3'd0 : idx_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      char_q       <= ch;
      run_end_q    <= last;
      stream_end_q <= last && job_i.fin;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign text_char_o  = char_q;
  assign run_end_o    = run_end_q;
  assign stream_end_o = stream_end_q;

endmodule
